### rtl/bam_tr_pkg.sv
// shared types and constants for the transport reassembler
package bam_tr_pkg;

  localparam int unsigned SESSIONS  = 4;
  localparam int unsigned MAX_BYTES = 1785;
  localparam int unsigned FILTERS   = 4;

  localparam int unsigned SLOT_W  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned ADDR_W  = SLOT_W + POS_W;
  localparam int unsigned MEM_DEPTH = SESSIONS * (2 ** POS_W);
  localparam int unsigned NFILT   = (FILTERS < 4) ? FILTERS : 4;

  localparam logic [17:0] PGN_TPCM    = 18'h0EC00;
  localparam logic [17:0] PGN_TPDT    = 18'h0EB00;
  localparam logic [7:0]  BAM_CTRL    = 8'h20;
  localparam logic [7:0]  PDU2_START  = 8'd240;
  localparam logic [2:0]  PKT_LAST    = 3'd6;
  localparam logic [4:0]  CHUNK_LAST  = 5'd31;
  localparam logic [POS_W-1:0] CLR_LAST = POS_W'(MAX_BYTES - 1);
  localparam logic [POS_W-1:0] SIZE_MAX = POS_W'(MAX_BYTES);

  // configuration register indexes
  localparam logic [2:0] REG_FILTER_COUNT = 3'd0;
  localparam logic [2:0] REG_FILTER_A     = 3'd1;
  localparam logic [2:0] REG_FILTER_B     = 3'd2;
  localparam logic [2:0] REG_FILTER_C     = 3'd3;
  localparam logic [2:0] REG_FILTER_D     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_WRITE,
    ST_CHECK,
    ST_GATHER,
    ST_SETTLE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic capture;
    logic open;
    logic pick;
    logic clr;
    logic wr;
    logic count;
    logic emit_start;
    logic rd;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic bam_ok;
    logic dt_ok;
    logic clr_last;
    logic wr_last;
    logic rd_last;
    logic done;
    logic pass;
    logic out_free;
    logic last_chunk;
  } status_t;

endpackage

### rtl/bam_transport_reassembler_top.sv
// Broadcast transport reassembler: receives CAN frames, emits 32-byte chunks.
// Input channel: one CAN frame per word (extended_i, can_id_i, data_len_i,
// payload_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one 32-byte chunk per word with session info, taken when
// out_valid_o is high and out_stall_i is low; last_o marks the final chunk.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 filter
// count, 1..4 filter PGNs); write only while the block is idle.
// Per frame: ignored frames return to idle after decode; data packets write
// up to seven payload bytes, one buffer byte per cycle; an announcement clears
// the first 1785 bytes of its session region, one byte a cycle. A completing
// packet then gathers each chunk through the single buffer read port.
// Reset clears the session table, filter and output valid flag; the buffer
// is not reset, each region is cleared when its session opens.
// While the receiver stalls, the current chunk holds in the output register
// and the next chunk waits assembled; once the final chunk is loaded a new
// frame is taken at once.
module bam_transport_reassembler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        extended_i,
  input  logic [28:0] can_id_i,
  input  logic [3:0]  data_len_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  source_addr_o,
  output logic [23:0] target_pgn_o,
  output logic [2:0]  prio_o,
  output logic [10:0] msg_len_o,
  output logic [5:0]  chunk_index_o,
  output logic [63:0] word_a_o,
  output logic [63:0] word_b_o,
  output logic [63:0] word_c_o,
  output logic [63:0] word_d_o,
  output logic        last_o
);

  bam_tr_pkg::cmd_t    cmd;
  bam_tr_pkg::status_t st;

  bam_tr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bam_tr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .extended_i    (extended_i),
    .can_id_i      (can_id_i),
    .data_len_i    (data_len_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .source_addr_o (source_addr_o),
    .target_pgn_o  (target_pgn_o),
    .prio_o        (prio_o),
    .msg_len_o     (msg_len_o),
    .chunk_index_o (chunk_index_o),
    .word_a_o      (word_a_o),
    .word_b_o      (word_b_o),
    .word_c_o      (word_c_o),
    .word_d_o      (word_d_o),
    .last_o        (last_o)
  );

endmodule

### rtl/bam_tr_ctrl.sv
// sequencer for decode, buffer clear, packet write and chunk emission
module bam_tr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bam_tr_pkg::status_t st_i,
  output bam_tr_pkg::cmd_t    cmd_o
);

  bam_tr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bam_tr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bam_tr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bam_tr_pkg::ST_DECODE;
      end
      bam_tr_pkg::ST_DECODE: begin
        if (st_i.bam_ok) state_d = bam_tr_pkg::ST_CLEAR;
        else if (st_i.dt_ok) state_d = bam_tr_pkg::ST_WRITE;
        else state_d = bam_tr_pkg::ST_IDLE;
      end
      bam_tr_pkg::ST_CLEAR: begin
        if (st_i.clr_last) state_d = bam_tr_pkg::ST_IDLE;
      end
      bam_tr_pkg::ST_WRITE: begin
        if (st_i.wr_last) state_d = bam_tr_pkg::ST_CHECK;
      end
      bam_tr_pkg::ST_CHECK: begin
        if (st_i.done && st_i.pass) state_d = bam_tr_pkg::ST_GATHER;
        else state_d = bam_tr_pkg::ST_IDLE;
      end
      bam_tr_pkg::ST_GATHER: begin
        if (st_i.rd_last) state_d = bam_tr_pkg::ST_SETTLE;
      end
      bam_tr_pkg::ST_SETTLE: begin
        state_d = bam_tr_pkg::ST_LOAD;
      end
      bam_tr_pkg::ST_LOAD: begin
        if (st_i.out_free) begin
          state_d = st_i.last_chunk ? bam_tr_pkg::ST_IDLE : bam_tr_pkg::ST_GATHER;
        end
      end
      default: state_d = bam_tr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bam_tr_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      bam_tr_pkg::ST_DECODE: begin
        cmd_o.open = st_i.bam_ok;
        cmd_o.pick = !st_i.bam_ok && st_i.dt_ok;
      end
      bam_tr_pkg::ST_CLEAR:  cmd_o.clr = 1'b1;
      bam_tr_pkg::ST_WRITE:  cmd_o.wr = 1'b1;
      bam_tr_pkg::ST_CHECK: begin
        cmd_o.count      = 1'b1;
        cmd_o.emit_start = st_i.done && st_i.pass;
      end
      bam_tr_pkg::ST_GATHER: cmd_o.rd = 1'b1;
      bam_tr_pkg::ST_SETTLE: cmd_o = '0;
      bam_tr_pkg::ST_LOAD:   cmd_o.load = st_i.out_free;
      default:               cmd_o = '0;
    endcase
  end

endmodule

### rtl/bam_tr_dp.sv
// session table, byte buffer, filter and output register
module bam_tr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bam_tr_pkg::cmd_t    cmd_i,
  output bam_tr_pkg::status_t st_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                extended_i,
  input  logic [28:0]         can_id_i,
  input  logic [3:0]          data_len_i,
  input  logic [63:0]         payload_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          source_addr_o,
  output logic [23:0]         target_pgn_o,
  output logic [2:0]          prio_o,
  output logic [10:0]         msg_len_o,
  output logic [5:0]          chunk_index_o,
  output logic [63:0]         word_a_o,
  output logic [63:0]         word_b_o,
  output logic [63:0]         word_c_o,
  output logic [63:0]         word_d_o,
  output logic                last_o
);

  localparam int unsigned SW = bam_tr_pkg::SLOT_W;
  localparam int unsigned PW = bam_tr_pkg::POS_W;

  // configuration
  logic [2:0]  fcount_q;
  logic [23:0] fpgn_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= '0;
      for (int i = 0; i < 4; i++) fpgn_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bam_tr_pkg::REG_FILTER_COUNT: fcount_q  <= cfg_data_i[2:0];
        bam_tr_pkg::REG_FILTER_A:     fpgn_q[0] <= cfg_data_i;
        bam_tr_pkg::REG_FILTER_B:     fpgn_q[1] <= cfg_data_i;
        bam_tr_pkg::REG_FILTER_C:     fpgn_q[2] <= cfg_data_i;
        bam_tr_pkg::REG_FILTER_D:     fpgn_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured frame
  logic        ext_q;
  logic [28:0] id_q;
  logic [3:0]  len_q;
  logic [63:0] pl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ext_q <= extended_i;
      id_q  <= can_id_i;
      len_q <= data_len_i;
      pl_q  <= payload_i;
    end
  end

  // session table
  logic           valid_q [bam_tr_pkg::SESSIONS];
  logic [7:0]     src_q   [bam_tr_pkg::SESSIONS];
  logic [PW-1:0]  size_q  [bam_tr_pkg::SESSIONS];
  logic [7:0]     pkts_q  [bam_tr_pkg::SESSIONS];
  logic [7:0]     rcv_q   [bam_tr_pkg::SESSIONS];
  logic [23:0]    pgn_q   [bam_tr_pkg::SESSIONS];
  logic [2:0]     prio_q  [bam_tr_pkg::SESSIONS];

  logic [SW-1:0]  cur_q;
  logic [PW-1:0]  cnt_q;
  logic [PW-1:0]  off_q;
  logic [5:0]     chunk_q;

  // decode
  logic [7:0]    pf, ps, src, seq;
  logic [17:0]   pgn;
  logic [PW-1:0] total;
  logic          frame_ok, hit, any_free;
  logic [SW-1:0] hit_idx, free_idx, slot_sel;
  logic [PW-1:0] seq_m1;
  logic [PW-1:0] off_d;

  always_comb begin
    pf    = id_q[23:16];
    ps    = id_q[15:8];
    src   = id_q[7:0];
    seq   = pl_q[7:0];
    pgn   = {id_q[25], id_q[24], pf, (pf >= bam_tr_pkg::PDU2_START) ? ps : 8'h00};
    total = pl_q[18:8];
    frame_ok = ext_q && (len_q >= 4'd8);
    hit = 1'b0;
    hit_idx = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = bam_tr_pkg::SESSIONS - 1; i >= 0; i--) begin
      if (valid_q[i] && src_q[i] == src) begin
        hit = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
    slot_sel = hit ? hit_idx : free_idx;
    st_o.bam_ok = frame_ok && pgn == bam_tr_pkg::PGN_TPCM &&
                  pl_q[7:0] == bam_tr_pkg::BAM_CTRL &&
                  pl_q[23:19] == 5'd0 && total <= bam_tr_pkg::SIZE_MAX &&
                  (hit || any_free);
    st_o.dt_ok = frame_ok && pgn == bam_tr_pkg::PGN_TPDT && hit &&
                 seq != 8'd0 && seq <= pkts_q[hit_idx];
    // (seq-1)*7 as (x<<3)-x
    seq_m1 = PW'(seq - 8'd1);
    off_d  = (seq_m1 << 3) - seq_m1;
  end

  // filter
  logic [2:0] nfil;
  logic       pass;
  always_comb begin
    nfil = (fcount_q > 3'(bam_tr_pkg::NFILT)) ? 3'(bam_tr_pkg::NFILT) : fcount_q;
    pass = (nfil == 3'd0);
    for (int i = 0; i < bam_tr_pkg::NFILT; i++) begin
      if (3'(i) < nfil && fpgn_q[i] == pgn_q[cur_q]) pass = 1'b1;
    end
  end

  logic [7:0]    rcv_next;
  logic [PW-1:0] wpos, rpos, cur_size;
  logic [2:0]    lane;
  logic [5:0]    nchunk_m1;

  always_comb begin
    cur_size  = size_q[cur_q];
    rcv_next  = rcv_q[cur_q] + 8'd1;
    lane      = cnt_q[2:0] + 3'd1;
    wpos      = off_q + cnt_q;
    rpos      = {chunk_q, 5'b00000} + cnt_q;
    nchunk_m1 = (cur_size == '0) ? 6'd0 : 6'((cur_size - PW'(1)) >> 5);
    st_o.clr_last   = cnt_q == bam_tr_pkg::CLR_LAST;
    st_o.wr_last    = cnt_q[2:0] == bam_tr_pkg::PKT_LAST;
    st_o.rd_last    = cnt_q[4:0] == bam_tr_pkg::CHUNK_LAST;
    st_o.done       = rcv_next == pkts_q[cur_q];
    st_o.pass       = pass;
    st_o.out_free   = !out_valid_o || !out_stall_i;
    st_o.last_chunk = chunk_q == nchunk_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bam_tr_pkg::SESSIONS; i++) begin
        valid_q[i] <= 1'b0;
        src_q[i]   <= '0;
        size_q[i]  <= '0;
        pkts_q[i]  <= '0;
        rcv_q[i]   <= '0;
        pgn_q[i]   <= '0;
        prio_q[i]  <= '0;
      end
      cur_q   <= '0;
      cnt_q   <= '0;
      off_q   <= '0;
      chunk_q <= '0;
    end else begin
      if (cmd_i.open) begin
        valid_q[slot_sel] <= 1'b1;
        src_q[slot_sel]   <= src;
        size_q[slot_sel]  <= total;
        pkts_q[slot_sel]  <= pl_q[31:24];
        rcv_q[slot_sel]   <= '0;
        pgn_q[slot_sel]   <= pl_q[63:40];
        prio_q[slot_sel]  <= id_q[28:26];
        cur_q <= slot_sel;
        cnt_q <= '0;
      end
      if (cmd_i.pick) begin
        cur_q <= hit_idx;
        off_q <= off_d;
        cnt_q <= '0;
      end
      if (cmd_i.clr || cmd_i.wr || cmd_i.rd) cnt_q <= cnt_q + PW'(1);
      if (cmd_i.count) begin
        rcv_q[cur_q] <= rcv_next;
        if (st_o.done) valid_q[cur_q] <= 1'b0;
      end
      if (cmd_i.emit_start) begin
        chunk_q <= '0;
        cnt_q   <= '0;
      end
      if (cmd_i.load) begin
        chunk_q <= chunk_q + 6'd1;
        cnt_q   <= '0;
      end
    end
  end

  // byte buffer, one region per session
  logic [7:0]        mem [bam_tr_pkg::MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic              rvalid_q, rin_q;
  logic [4:0]        rlane_q;
  logic              we;
  logic [PW-1:0]     waddr_pos;
  logic [7:0]        wdata;

  always_comb begin
    we        = cmd_i.clr || (cmd_i.wr && wpos < cur_size);
    waddr_pos = cmd_i.clr ? cnt_q : wpos;
    wdata     = cmd_i.clr ? 8'h00 : pl_q[{lane, 3'b000} +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[{cur_q, waddr_pos}] <= wdata;
    if (cmd_i.rd) rdata_q <= mem[{cur_q, rpos}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rlane_q <= cnt_q[4:0];
      rin_q   <= rpos < cur_size;
    end
  end

  // chunk assembly
  logic [7:0] asm_q [32];
  always_ff @(posedge clk_i) begin
    if (rvalid_q) asm_q[rlane_q] <= rin_q ? rdata_q : 8'h00;
  end

  logic [255:0] asm_flat;
  always_comb begin
    for (int i = 0; i < 32; i++) asm_flat[8*i +: 8] = asm_q[i];
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      source_addr_o <= src_q[cur_q];
      target_pgn_o  <= pgn_q[cur_q];
      prio_o        <= prio_q[cur_q];
      msg_len_o     <= cur_size;
      chunk_index_o <= chunk_q;
      word_a_o      <= asm_flat[63:0];
      word_b_o      <= asm_flat[127:64];
      word_c_o      <= asm_flat[191:128];
      word_d_o      <= asm_flat[255:192];
      last_o        <= st_o.last_chunk;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i)) else $error("load over held word");
  a_open_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open |=> valid_q[cur_q]) else $error("opened slot not valid");
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> cnt_q < PW'(7)) else $error("packet write overrun");
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> chunk_q <= 6'd55) else $error("chunk index overrun");

endmodule

### dv/bam_transport_reassembler_top_tb.sv
// self-checking testbench for the transport reassembler: directed frames, then random sessions
`timescale 1ns / 100ps

module bam_transport_reassembler_top_tb;

  typedef struct {
    logic [7:0]  src;
    logic [23:0] pgn;
    logic [2:0]  prio;
    logic [10:0] size;
    logic [5:0]  idx;
    logic [63:0] wa, wb, wc, wd;
    logic        last;
  } chunk_t;

  typedef struct {
    bit          typed;
    int          n_typed;
    logic        ext;
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] pl;
    chunk_t      want;
  } frame_row_t;

  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int SETTLE_CYCLES = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        extended_i;
  logic [28:0] can_id_i;
  logic [3:0]  data_len_i;
  logic [63:0] payload_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  source_addr_o;
  logic [23:0] target_pgn_o;
  logic [2:0]  prio_o;
  logic [10:0] msg_len_o;
  logic [5:0]  chunk_index_o;
  logic [63:0] word_a_o, word_b_o, word_c_o, word_d_o;
  logic        last_o;

  bam_transport_reassembler_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // session table mirror
  logic        sess_valid [bam_tr_pkg::SESSIONS];
  logic [7:0]  sess_src   [bam_tr_pkg::SESSIONS];
  logic [10:0] sess_size  [bam_tr_pkg::SESSIONS];
  logic [7:0]  sess_pkts  [bam_tr_pkg::SESSIONS];
  logic [7:0]  sess_rx    [bam_tr_pkg::SESSIONS];
  logic [23:0] sess_pgn   [bam_tr_pkg::SESSIONS];
  logic [2:0]  sess_prio  [bam_tr_pkg::SESSIONS];
  logic [7:0]  sess_buf   [bam_tr_pkg::SESSIONS][bam_tr_pkg::MAX_BYTES];
  logic [2:0]  filt_cnt;
  logic [23:0] filt_pgn [4];

  chunk_t     chunk_q[$];
  frame_row_t rows[$];
  int         errs = 0;
  int         cycles = 0;
  int         frames_sent = 0;
  bit         no_gaps = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errs++;
  endtask

  function automatic logic [28:0] mk_id(input logic [2:0] prio, input logic [7:0] pf,
                                        input logic [7:0] ps, input logic [7:0] src);
    return {prio, 2'b00, pf, ps, src};
  endfunction

  function automatic logic [63:0] bam_pl(input logic [15:0] size, input logic [7:0] pkts,
                                         input logic [23:0] pgn);
    return {pgn, 8'hFF, pkts, size, bam_tr_pkg::BAM_CTRL};
  endfunction

  function automatic bit pgn_passes(input logic [23:0] pgn);
    int n;
    n = (filt_cnt > bam_tr_pkg::NFILT) ? int'(bam_tr_pkg::NFILT) : int'(filt_cnt);
    if (n == 0) return 1;
    for (int i = 0; i < n; i++)
      if (filt_pgn[i] == pgn) return 1;
    return 0;
  endfunction

  task automatic emit_chunks(input int s, input bit keep);
    int     nchunks;
    int     pos;
    chunk_t c;
    logic [63:0] w [4];
    nchunks = (sess_size[s] + 31) / 32;
    if (nchunks == 0) nchunks = 1;
    for (int k = 0; k < nchunks; k++) begin
      for (int j = 0; j < 4; j++) begin
        w[j] = '0;
        for (int b = 0; b < 8; b++) begin
          pos = k * 32 + j * 8 + b;
          if (pos < sess_size[s]) w[j][8*b +: 8] = sess_buf[s][pos];
        end
      end
      c = '{src: sess_src[s], pgn: sess_pgn[s], prio: sess_prio[s], size: sess_size[s],
            idx: 6'(k), wa: w[0], wb: w[1], wc: w[2], wd: w[3], last: (k == nchunks - 1)};
      if (keep) chunk_q.push_back(c);
    end
  endtask

  // frame decode and session update; completed, filter-passing messages go to chunk_q if keep
  task automatic model_frame(input logic ext, input logic [28:0] id, input logic [3:0] len,
                             input logic [63:0] pl, input bit keep);
    logic [17:0] pgn;
    logic [15:0] total;
    logic [7:0]  src, seq;
    int          s, off;
    if (!ext || len < 8) return;
    src = id[7:0];
    pgn = {id[25], id[24], id[23:16], 8'h00};
    if (id[23:16] >= bam_tr_pkg::PDU2_START) pgn[7:0] = id[15:8];
    s = -1;
    for (int i = 0; i < bam_tr_pkg::SESSIONS; i++)
      if (s < 0 && sess_valid[i] && sess_src[i] == src) s = i;
    if (pgn == bam_tr_pkg::PGN_TPCM) begin
      if (pl[7:0] != bam_tr_pkg::BAM_CTRL) return;
      total = pl[23:8];
      if (total > bam_tr_pkg::MAX_BYTES) return;
      for (int i = 0; i < bam_tr_pkg::SESSIONS; i++)
        if (s < 0 && !sess_valid[i]) s = i;
      if (s < 0) return;
      sess_valid[s] = 1;
      sess_src[s]   = src;
      sess_size[s]  = total[10:0];
      sess_pkts[s]  = pl[31:24];
      sess_rx[s]    = 0;
      sess_pgn[s]   = pl[63:40];
      sess_prio[s]  = id[28:26];
      for (int i = 0; i < bam_tr_pkg::MAX_BYTES; i++) sess_buf[s][i] = 0;
    end else if (pgn == bam_tr_pkg::PGN_TPDT) begin
      if (s < 0) return;
      seq = pl[7:0];
      if (seq < 1 || seq > sess_pkts[s]) return;
      off = (seq - 1) * 7;
      for (int i = 0; i < 7; i++)
        if (off + i < sess_size[s]) sess_buf[s][off + i] = pl[8*(i+1) +: 8];
      sess_rx[s] = sess_rx[s] + 8'd1;
      if (sess_rx[s] == sess_pkts[s]) begin
        if (pgn_passes(sess_pgn[s])) emit_chunks(s, keep);
        sess_valid[s] = 0;
      end
    end
  endtask

  // hands one frame over, returns after the accepting edge
  task automatic drive_frame(input logic ext, input logic [28:0] id, input logic [3:0] len,
                             input logic [63:0] pl);
    int  gap;
    bit  taken;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    extended_i <= ext;
    can_id_i   <= id;
    data_len_i <= len;
    payload_i  <= pl;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    frames_sent++;
    if (frames_sent % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_frame(input logic ext, input logic [28:0] id, input logic [3:0] len,
                            input logic [63:0] pl);
    drive_frame(ext, id, len, pl);
    model_frame(ext, id, len, pl, 1);
  endtask

  task automatic send_noise();
    send_frame(1'($urandom_range(0, 1)), 29'($urandom), 4'($urandom_range(0, 15)),
               {$urandom, $urandom});
  endtask

  task automatic drain_idle();
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == bam_tr_pkg::REG_FILTER_COUNT) filt_cnt = data[2:0];
    else filt_pgn[idx - 3'd1] = data;
  endtask

  task automatic add_row(input bit typed, input int n, input logic ext, input logic [28:0] id,
                         input logic [3:0] len, input logic [63:0] pl, input chunk_t want);
    rows.push_back('{typed: typed, n_typed: n, ext: ext, id: id, len: len, pl: pl,
                     want: want});
  endtask

  // one announced message with random content, some bad, repeated or foreign words mixed in
  task automatic run_session(input int max_size, output int used);
    logic [7:0]  src, pkts, seq;
    logic [15:0] size;
    logic [23:0] pgn;
    logic [2:0]  prio;
    src  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    size = 16'($urandom_range(0, max_size));
    if ($urandom_range(0, 30) == 0) size = 16'($urandom_range(bam_tr_pkg::MAX_BYTES + 1, 65535));
    pkts = (size == 0) ? 8'd1 : 8'((size + 6) / 7);
    if ($urandom_range(0, 9) == 0) pkts = 8'($urandom_range(0, 20));
    pgn  = ($urandom_range(0, 2) == 0) ? 24'($urandom) : filt_pgn[$urandom_range(0, 3)];
    prio = 3'($urandom_range(0, 7));
    used = 1;
    send_frame(1'b1, mk_id(prio, 8'hEC, 8'($urandom), src), 4'd8,
               ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : bam_pl(size, pkts, pgn));
    for (int k = 1; k <= pkts; k++) begin
      seq = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, pkts + 1)) : 8'(k);
      if ($urandom_range(0, 9) == 0) send_noise();
      send_frame(1'b1, mk_id(3'($urandom_range(0, 7)), 8'hEB, 8'($urandom), src),
                 ($urandom_range(0, 30) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
                 {$urandom, 24'($urandom), seq});
      used++;
    end
  endtask

  task automatic random_phase(input int n_items);
    int done_items, used;
    done_items = 0;
    while (done_items < n_items) begin
      run_session(($urandom_range(0, 7) == 0) ? 300 : 80, used);
      done_items += used;
    end
  endtask

  // receiver: random stall ahead of each word, check against the oldest expectation
  initial begin : receiver
    bit     taken;
    int     hold;
    chunk_t got, want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o && !out_stall_i;
        got = '{src: source_addr_o, pgn: target_pgn_o, prio: prio_o, size: msg_len_o,
                idx: chunk_index_o, wa: word_a_o, wb: word_b_o, wc: word_c_o,
                wd: word_d_o, last: last_o};
        if (!taken) @(posedge clk_i);
      end while (!taken);
      if (chunk_q.size() == 0) begin
        report("unexpected word", 64'(got.idx), 64'd0);
      end else begin
        want = chunk_q.pop_front();
        if (got.src  !== want.src)  report("source_addr", 64'(got.src), 64'(want.src));
        if (got.pgn  !== want.pgn)  report("target_pgn", 64'(got.pgn), 64'(want.pgn));
        if (got.prio !== want.prio) report("prio", 64'(got.prio), 64'(want.prio));
        if (got.size !== want.size) report("msg_len", 64'(got.size), 64'(want.size));
        if (got.idx  !== want.idx)  report("chunk_index", 64'(got.idx), 64'(want.idx));
        if (got.wa   !== want.wa)   report("word_a", got.wa, want.wa);
        if (got.wb   !== want.wb)   report("word_b", got.wb, want.wb);
        if (got.wc   !== want.wc)   report("word_c", got.wc, want.wc);
        if (got.wd   !== want.wd)   report("word_d", got.wd, want.wd);
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  initial begin : stimulus
    chunk_t none, empty_msg;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bam_tr_pkg::REG_FILTER_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    extended_i = 1'b0;
    can_id_i = '0;
    data_len_i = '0;
    payload_i = '0;
    filt_cnt = 0;
    for (int i = 0; i < 4; i++) filt_pgn[i] = 0;
    for (int i = 0; i < bam_tr_pkg::SESSIONS; i++) begin
      sess_valid[i] = 0; sess_src[i] = 0; sess_size[i] = 0; sess_pkts[i] = 0;
      sess_rx[i] = 0; sess_pgn[i] = 0; sess_prio[i] = 0;
    end
    none = '{src: 0, pgn: 0, prio: 0, size: 0, idx: 0, wa: 0, wb: 0, wc: 0, wd: 0, last: 0};
    empty_msg = '{src: 8'h11, pgn: 24'h00FECA, prio: 3'd7, size: 11'd0, idx: 6'd0,
                  wa: 0, wb: 0, wc: 0, wd: 0, last: 1'b1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // standard id frame is dropped even though it looks like an announcement
    add_row(1, 0, 0, mk_id(0, 8'hEC, 8'hFF, 8'h11), 8, bam_pl(0, 1, 24'hFECA), none);
    // empty message: one all-zero chunk
    add_row(1, 0, 1, mk_id(7, 8'hEC, 8'hFF, 8'h11), 8, bam_pl(0, 1, 24'hFECA), none);
    add_row(1, 1, 1, mk_id(0, 8'hEB, 8'hFF, 8'h11), 8, 64'hFFFFFFFFFFFFFF01, empty_msg);
    // short announcement, oversized announcement, data with no session
    add_row(1, 0, 1, mk_id(1, 8'hEC, 8'hFF, 8'h22), 7, bam_pl(9, 2, 24'h123456), none);
    add_row(1, 0, 1, mk_id(1, 8'hEC, 8'hFF, 8'h22), 8, bam_pl(1786, 255, 24'h1), none);
    add_row(1, 0, 1, mk_id(1, 8'hEB, 8'hFF, 8'h22), 8, 64'h0102030405060701, none);
    // bad sequence numbers, length above eight, duplicate completes the count
    add_row(0, 0, 1, mk_id(0, 8'hEC, 8'h00, 8'h22), 8, bam_pl(9, 2, 24'h123456), none);
    add_row(1, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h22), 8, 64'hAAAAAAAAAAAAAA00, none);
    add_row(1, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h22), 8, 64'hAAAAAAAAAAAAAA03, none);
    add_row(0, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h22), 15, 64'h1122334455667702, none);
    add_row(0, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h22), 8, 64'h99887766554433_02, none);
    // restart mid-message clears the buffer and the count
    add_row(0, 0, 1, mk_id(3, 8'hEC, 8'h00, 8'h33), 8, bam_pl(20, 3, 24'hFFFFFF), none);
    add_row(0, 0, 1, mk_id(3, 8'hEB, 8'h00, 8'h33), 8, 64'hDEADBEEFCAFE0101, none);
    add_row(0, 0, 1, mk_id(5, 8'hEC, 8'h00, 8'h33), 8, bam_pl(14, 2, 24'h000000), none);
    add_row(0, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h33), 8, 64'h0F0E0D0C0B0A0902, none);
    add_row(0, 0, 1, mk_id(0, 8'hEB, 8'h00, 8'h33), 8, 64'h1716151413121101, none);
    // zero-packet sessions fill every slot, the next new source is dropped
    add_row(0, 0, 1, mk_id(2, 8'hEC, 8'h00, 8'h01), 8, bam_pl(5, 0, 24'h1), none);
    add_row(0, 0, 1, mk_id(2, 8'hEC, 8'h00, 8'h02), 8, bam_pl(5, 0, 24'h2), none);
    add_row(0, 0, 1, mk_id(2, 8'hEC, 8'h00, 8'h03), 8, bam_pl(5, 0, 24'h3), none);
    add_row(0, 0, 1, mk_id(2, 8'hEC, 8'h00, 8'h04), 8, bam_pl(5, 0, 24'h4), none);
    add_row(1, 0, 1, mk_id(2, 8'hEC, 8'h00, 8'h05), 8, bam_pl(7, 1, 24'h5), none);
    add_row(1, 0, 1, mk_id(2, 8'hEB, 8'h00, 8'h05), 8, 64'hFFFFFFFFFFFFFF01, none);
    add_row(1, 0, 1, mk_id(2, 8'hEB, 8'h00, 8'h01), 8, 64'hFFFFFFFFFFFFFF01, none);
    // restart a stuck one and complete it
    add_row(0, 0, 1, mk_id(6, 8'hEC, 8'h00, 8'h01), 8, bam_pl(7, 1, 24'hABCDEF), none);
    add_row(0, 0, 1, mk_id(6, 8'hEB, 8'h00, 8'h01), 8, 64'h0706050403020101, none);

    foreach (rows[i]) begin
      drive_frame(rows[i].ext, rows[i].id, rows[i].len, rows[i].pl);
      model_frame(rows[i].ext, rows[i].id, rows[i].len, rows[i].pl, !rows[i].typed);
      if (rows[i].typed && rows[i].n_typed == 1) chunk_q.push_back(rows[i].want);
    end
    random_phase(16);

    // two filters in use
    in_valid_i <= 1'b0;
    drain_idle();
    write_reg(bam_tr_pkg::REG_FILTER_A, 24'h00FEF1);
    write_reg(bam_tr_pkg::REG_FILTER_B, 24'h000000);
    write_reg(bam_tr_pkg::REG_FILTER_COUNT, 24'd2);
    random_phase(16);

    // count above the maximum, all four filters, extreme values
    in_valid_i <= 1'b0;
    drain_idle();
    write_reg(bam_tr_pkg::REG_FILTER_C, 24'hFFFFFF);
    write_reg(bam_tr_pkg::REG_FILTER_D, 24'h01A2B3);
    write_reg(bam_tr_pkg::REG_FILTER_COUNT, 24'd7);
    random_phase(16);

    // largest message, accepting everything
    in_valid_i <= 1'b0;
    drain_idle();
    write_reg(bam_tr_pkg::REG_FILTER_COUNT, 24'd0);
    send_frame(1, mk_id(7, 8'hEC, 8'h00, 8'hFF), 8,
               bam_pl(16'(bam_tr_pkg::MAX_BYTES), 255, 24'h3FFFF));
    for (int k = 1; k <= 255; k++)
      send_frame(1, mk_id(7, 8'hEB, 8'h00, 8'hFF), 8, {$urandom, 24'($urandom), 8'(k)});
    random_phase(10);

    in_valid_i <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
